// File: rtl/tlg_pkg.sv
// ----------------------------------------------------------------------------
// tlg_pkg
// shared types and constants for the toroidal life generation unit
// ----------------------------------------------------------------------------
package tlg_pkg;

   localparam int MaxRows = 64;
   localparam int MaxCols = 64;
   localparam int RowW    = $clog2(MaxRows);
   localparam int ColW    = $clog2(MaxCols);
   localparam int AddrW   = RowW + ColW;
   localparam int SizeW   = 7;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_STEP = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   // clamp a size register to 1..max
   function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                   input logic [SizeW-1:0] maxv);
      logic [SizeW-1:0] r;
      begin
         r = v;
         if (v == '0) r = SizeW'(1);
         else if (v > maxv) r = maxv;
         return r;
      end
   endfunction

endpackage

// File: rtl/toroidal_life_generation_unit.sv
// ----------------------------------------------------------------------------
// toroidal_life_generation_unit
// conway life on a torus with a sequenced single-port neighbor counter
// ----------------------------------------------------------------------------
// A load answers from the response state after its transfer; a read goes
// through S_READ and S_CWAIT and then answers. A step scans all 4096 cell
// slots in order: a cell inside the active area makes one grid read per
// neighborhood position through the single read port of the grid memory,
// accumulated in a shared counter, while a slot outside the area is
// passed without reads. The sweep is followed by a copy of the scratch
// grid back and the result, so the length of a step is set by the number
// of active cells. After reset a clearing pass over all 4096 cell slots
// empties the grid before the first item is taken. The input is not ready
// while an item is in work; a finished result waits in the output
// register, and the next item is taken only once it is gone. An item with
// the unused operation code is taken and dropped without a result.
module toroidal_life_generation_unit
   import tlg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [15:0] req_tdata,   // cell_row[5:0], cell_col[11:6], cell_value[12]
   input  logic [1:0] req_tuser,    // operation
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // read_alive[0]
   output logic [1:0] rsp_tuser,    // done_operation
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [6:0] csr_data
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_SUM   = 7'b0001000,
      S_COPY  = 7'b0010000,
      S_RESP  = 7'b0100000,
      S_CWAIT = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [SizeW-1:0] rows_ff, cols_ff;
   logic [AddrW:0]   idx_ff, idx_in;       // sweep index, top bit flags end
   logic [3:0]       nb_ff, nb_in;         // neighborhood position 0..8
   logic [3:0]       cnt_ff, cnt_in;
   logic             self_ff, self_in;
   logic             pend_ff, pend_in;     // a read word is in flight
   logic [3:0]       pnb_ff;
   logic [AddrW-1:0] paddr_ff;
   op_type           op_ff;
   logic [RowW-1:0]  row_ff;
   logic [ColW-1:0]  col_ff;
   logic             val_ff;
   logic             rv_ff, rv_in;
   logic             alive_ff, alive_in;

   logic [SizeW-1:0] rows, cols;
   logic             g_we, g_wd, g_rd, n_we, n_wd, n_rd;
   logic [AddrW-1:0] g_wa, g_ra, n_wa, n_ra;

   assign rows = clamp_size(rows_ff, SizeW'(MaxRows));
   assign cols = clamp_size(cols_ff, SizeW'(MaxCols));

   tlg_ram u_grid (.clock, .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
                   .rd_addr(g_ra), .rd_data(g_rd));
   tlg_ram u_next (.clock, .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
                   .rd_addr(n_ra), .rd_data(n_rd));

   // current cell of the sweep and its wrapped neighbor address
   logic [RowW-1:0] cr, nr;
   logic [ColW-1:0] cc, nc;
   logic [SizeW:0]  tr, tc;
   logic            act;
   always_comb begin
      cr = idx_ff[AddrW-1:ColW];
      cc = idx_ff[ColW-1:0];
      act = ({1'b0, cr} < rows) && ({1'b0, cc} < cols);
      // row offset nb/3 - 1, col offset nb%3 - 1 done by small decode
      tr = {2'b0, cr} + {1'b0, rows};
      tc = {2'b0, cc} + {1'b0, cols};
      case (nb_ff)
         4'd0, 4'd1, 4'd2: tr = tr - (SizeW+1)'(1);
         4'd6, 4'd7, 4'd8: tr = tr + (SizeW+1)'(1);
         default: ;
      endcase
      case (nb_ff)
         4'd0, 4'd3, 4'd6: tc = tc - (SizeW+1)'(1);
         4'd2, 4'd5, 4'd8: tc = tc + (SizeW+1)'(1);
         default: ;
      endcase
      // value lies in [rows-1, 2*rows]: at most two subtracts
      if (tr >= {1'b0, rows}) tr = tr - {1'b0, rows};
      if (tr >= {1'b0, rows}) tr = tr - {1'b0, rows};
      if (tc >= {1'b0, cols}) tc = tc - {1'b0, cols};
      if (tc >= {1'b0, cols}) tc = tc - {1'b0, cols};
      nr = tr[RowW-1:0];
      nc = tc[ColW-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      nb_in    = nb_ff;
      cnt_in   = cnt_ff;
      self_in  = self_ff;
      pend_in  = 1'b0;
      rv_in    = rv_ff;
      alive_in = alive_ff;
      g_we = 1'b0; g_wa = idx_ff[AddrW-1:0]; g_wd = 1'b0;
      g_ra = {row_ff, col_ff};
      n_we = 1'b0; n_wa = idx_ff[AddrW-1:0]; n_wd = 1'b0;
      n_ra = idx_ff[AddrW-1:0];
      if (rsp_tvalid && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            g_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff[AddrW-1:0] == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               idx_in = '0; nb_in = '0; cnt_in = '0;
               unique case (op_type'(req_tuser))
                  OP_LOAD: state_in = S_RESP;
                  OP_STEP: state_in = S_SUM;
                  OP_READ: state_in = S_READ;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: state_in = S_CWAIT;
         S_CWAIT: begin
            alive_in = g_rd && ({1'b0, row_ff} < rows) && ({1'b0, col_ff} < cols);
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         S_SUM: begin
            // issue one neighbor read per cycle for an active cell, accumulate the previous
            g_ra = {nr, nc};
            if (pend_ff) begin
               if (pnb_ff == 4'd4) self_in = g_rd;
               else cnt_in = cnt_ff + {3'b0, g_rd};
            end
            if (!idx_ff[AddrW]) begin
               if (pend_ff && pnb_ff == 4'd8) begin
                  // result of the previous cell
                  n_we = 1'b1;
                  n_wa = paddr_ff;
                  n_wd = (cnt_in == 4'd3) || ((cnt_in == 4'd2) && self_in);
                  cnt_in = '0;
               end
               if (!act) begin
                  n_we = n_we || 1'b0;
                  // inactive cells skip the scan; cleared during copy
                  idx_in = idx_ff + 1'b1;
                  nb_in = '0;
               end else begin
                  pend_in = 1'b1;
                  if (nb_ff == 4'd8) begin
                     nb_in = '0;
                     idx_in = idx_ff + 1'b1;
                  end else nb_in = nb_ff + 1'b1;
               end
            end else begin
               if (pend_ff && pnb_ff == 4'd8) begin
                  n_we = 1'b1;
                  n_wa = paddr_ff;
                  n_wd = (cnt_in == 4'd3) || ((cnt_in == 4'd2) && self_in);
               end
               idx_in = '0;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            // read scratch at the sweep index, write back the registered word read before it
            n_ra = idx_ff[AddrW-1:0];
            if (pend_ff) begin
               g_we = 1'b1;
               g_wa = paddr_ff;
               g_wd = n_rd && ({1'b0, paddr_ff[AddrW-1:ColW]} < rows)
                      && ({1'b0, paddr_ff[ColW-1:0]} < cols);
            end
            if (!idx_ff[AddrW]) begin
               pend_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (op_ff == OP_LOAD && ({1'b0, row_ff} < rows) && ({1'b0, col_ff} < cols)) begin
               g_we = 1'b1;
               g_wa = {row_ff, col_ff};
               g_wd = val_ff;
            end
            alive_in = 1'b0;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {7'b0, alive_ff};
   assign rsp_tuser  = op_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         nb_ff    <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
         rows_ff  <= SizeW'(MaxRows);
         cols_ff  <= SizeW'(MaxCols);
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         nb_ff    <= nb_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROWS) rows_ff <= csr_data;
            else cols_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      self_ff  <= self_in;
      alive_ff <= alive_in;
      pnb_ff   <= nb_ff;
      paddr_ff <= idx_ff[AddrW-1:0];
      if (req_tvalid && req_tready) begin
         op_ff  <= op_type'(req_tuser);
         row_ff <= req_tdata[RowW-1:0];
         col_ff <= req_tdata[AddrW-1:RowW];
         val_ff <= req_tdata[AddrW];
      end
   end

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_resp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_copy_after_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY |-> $past(state_ff) == S_SUM || $past(state_ff) == S_COPY)
      else $error("copy without sweep");

endmodule

// File: rtl/tlg_ram.sv
// ----------------------------------------------------------------------------
// tlg_ram
// one-bit grid memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tlg_ram
   import tlg_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic             wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic             rd_data
);

   logic mem [0:(1<<AddrW)-1];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
